// File: design/min_max_mean_stddev_macros.svh
// ----------------------------------------------------------------------------
// min_max_mean_stddev assertion macros
// Shared property forms for the statistics block checkers.
// ----------------------------------------------------------------------------
`ifndef MIN_MAX_MEAN_STDDEV_MACROS_SVH
`define MIN_MAX_MEAN_STDDEV_MACROS_SVH

// same-cycle implication
`define MMMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MMMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/mmms_pkg.sv
// ----------------------------------------------------------------------------
// mmms_pkg
// Types and fixed widths of the min/max/mean/stddev block.
// ----------------------------------------------------------------------------
package mmms_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int FRAC_BITS   = 8;
    localparam int MEAN_W      = 24;
    localparam int SD_W        = 24;
    localparam int COUNT_W     = 17;
    localparam int DP_W        = 64;
    localparam int ITER_W      = 7;
    localparam int SQRT_ITERS  = DP_W / 2;

    typedef enum logic [0:0] {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t          op;
        logic [DP_W-1:0]  a;
        logic [DP_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic [DP_W-1:0]  result;
        logic             borrow;
    } alu_rsp_t;

endpackage

// File: design/mmms_alu.sv
// ----------------------------------------------------------------------------
// mmms_alu
// Shared wide add/subtract unit with borrow out.
// ----------------------------------------------------------------------------
module mmms_alu (
    input  mmms_pkg::alu_req_t req,
    output mmms_pkg::alu_rsp_t rsp
);
    import mmms_pkg::*;

    logic [DP_W:0] full;

    always_comb
    begin
        unique case (req.op)
            ALU_ADD: full = {1'b0, req.a} + {1'b0, req.b};
            ALU_SUB: full = {1'b0, req.a} - {1'b0, req.b};
            default: full = '0;
        endcase
        rsp.result = full[DP_W-1:0];
        rsp.borrow = (req.op == ALU_SUB) ? full[DP_W] : 1'b0;
    end

endmodule

// File: design/mmms_accum.sv
// ----------------------------------------------------------------------------
// mmms_accum
// Running min, max, count, sum and sum of squares of accepted samples, up to MAX_COUNT of them, with an overflow flag.
// ----------------------------------------------------------------------------
module mmms_accum #(
    parameter int MAX_COUNT = 65536,
    parameter int CNT_W     = 17,
    parameter int SUM_W     = 33,
    parameter int SQ_W      = 48
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  logic                                  last,
    input  logic signed [mmms_pkg::SAMPLE_BITS-1:0] sample,
    output logic signed [mmms_pkg::SAMPLE_BITS-1:0] min_next,
    output logic signed [mmms_pkg::SAMPLE_BITS-1:0] max_next,
    output logic signed [SUM_W-1:0]               sum_next,
    output logic [SQ_W-1:0]                       sumsq_next,
    output logic [CNT_W-1:0]                      count_next,
    output logic                                  ovf_next
);
    import mmms_pkg::*;

    logic signed [SAMPLE_BITS-1:0] min_reg;
    logic signed [SAMPLE_BITS-1:0] max_reg;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sumsq_reg;
    logic [CNT_W-1:0]              count_reg;
    logic                          ovf_reg;
    logic [SAMPLE_BITS:0]          mag;
    logic [2*SAMPLE_BITS+1:0]      square;
    logic                          room;

    always_comb
    begin
        mag    = sample[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-$signed({sample[SAMPLE_BITS-1], sample}))
                                       : {1'b0, sample};
        square = (2*SAMPLE_BITS+2)'(mag) * (2*SAMPLE_BITS+2)'(mag);
        room   = count_reg < CNT_W'(MAX_COUNT);
        min_next   = min_reg;
        max_next   = max_reg;
        sum_next   = sum_reg;
        sumsq_next = sumsq_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (room)
        begin
            if (count_reg == '0)
            begin
                min_next = sample;
                max_next = sample;
            end
            else
            begin
                if (sample < min_reg) min_next = sample;
                if (sample > max_reg) max_next = sample;
            end
            sum_next   = sum_reg + SUM_W'(sample);
            sumsq_next = sumsq_reg + SQ_W'(square);
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= '0;
            max_reg   <= '0;
            sum_reg   <= '0;
            sumsq_reg <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last)
            begin
                min_reg   <= '0;
                max_reg   <= '0;
                sum_reg   <= '0;
                sumsq_reg <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                min_reg   <= min_next;
                max_reg   <= max_next;
                sum_reg   <= sum_next;
                sumsq_reg <= sumsq_next;
                count_reg <= count_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

// File: design/min_max_mean_stddev.sv
// ----------------------------------------------------------------------------
// min_max_mean_stddev
// Streaming min, max, mean and population standard deviation of a sample set.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while no set is computing and no result
// is pending. The sample marked last closes the set: the block then runs a
// sequencer over one shared 64-bit add/subtract unit (shift-add products
// n*sumsq, sum^2 and n^2, a difference, two 64-step restoring divisions, the
// variance one with 16 extra fraction steps, and a 32-step square root), with
// ready low from the last sample to the result. The result then waits in an
// output register and the next set starts once it is taken.
module min_max_mean_stddev #(
    parameter int MAX_COUNT = 65536
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [mmms_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                   last_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [mmms_pkg::SAMPLE_BITS-1:0] minimum,
    output logic signed [mmms_pkg::SAMPLE_BITS-1:0] maximum,
    output logic signed [mmms_pkg::MEAN_W-1:0]      mean_q8,
    output logic [mmms_pkg::SD_W-1:0]               stddev_q8,
    output logic [mmms_pkg::COUNT_W-1:0]            sample_count,
    output logic                                   overflow
);
    import mmms_pkg::*;

    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int SQ_W  = 2 * SAMPLE_BITS + CNT_W;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_MUL_NS   = 9'b000000010,
        ST_MUL_S2   = 9'b000000100,
        ST_DIFF     = 9'b000001000,
        ST_MUL_NN   = 9'b000010000,
        ST_DIV_MEAN = 9'b000100000,
        ST_DIV_VAR  = 9'b001000000,
        ST_SQRT     = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ITER_W-1:0]       iter_reg, iter_next;
    logic [DP_W-1:0]         mx_reg, mx_next;
    logic [DP_W-1:0]         my_reg, my_next;
    logic [DP_W-1:0]         acc_reg, acc_next;
    logic [DP_W-1:0]         num_reg, num_next;
    logic [DP_W-1:0]         den_reg, den_next;
    logic [SUM_W-1:0]        smag_reg;
    logic                    neg_reg;
    logic [CNT_W-1:0]        n_reg;
    logic signed [SAMPLE_BITS-1:0] min_hold_reg, max_hold_reg;
    logic                    ovf_hold_reg;
    logic [MEAN_W-1:0]       mean_reg, mean_next;
    logic                    out_valid_reg;

    logic                    accept;
    logic signed [SAMPLE_BITS-1:0] min_n, max_n;
    logic signed [SUM_W-1:0] sum_n;
    logic [SQ_W-1:0]         sumsq_n;
    logic [CNT_W-1:0]        count_n;
    logic                    ovf_n;
    alu_req_t                alu_req;
    alu_rsp_t                alu_rsp;
    logic [DP_W-1:0]         rem_shift;
    logic [DP_W-1:0]         divisor;
    logic                    iter_done;

    assign in_ready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign iter_done = (iter_reg == '0);

    mmms_accum #(
        .MAX_COUNT (MAX_COUNT),
        .CNT_W     (CNT_W),
        .SUM_W     (SUM_W),
        .SQ_W      (SQ_W)
    ) u_accum (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .last       (last_sample),
        .sample     (sample),
        .min_next   (min_n),
        .max_next   (max_n),
        .sum_next   (sum_n),
        .sumsq_next (sumsq_n),
        .count_next (count_n),
        .ovf_next   (ovf_n)
    );

    mmms_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb
    begin
        rem_shift = {acc_reg[DP_W-2:0], my_reg[DP_W-1]};
        divisor   = (state_reg == ST_DIV_MEAN) ? DP_W'(n_reg) : den_reg;
        alu_req.op = ALU_ADD;
        alu_req.a  = acc_reg;
        alu_req.b  = my_reg[0] ? mx_reg : '0;
        unique case (state_reg)
            ST_DIFF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = num_reg;
                alu_req.b  = acc_reg;
            end
            ST_DIV_MEAN, ST_DIV_VAR:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = rem_shift;
                alu_req.b  = divisor;
            end
            ST_SQRT:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = num_reg;
                alu_req.b  = mx_reg | my_reg;
            end
            default:
            begin
                alu_req.op = ALU_ADD;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg - ITER_W'(1);
        mx_next    = mx_reg;
        my_next    = my_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        mean_next  = mean_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                iter_next = iter_reg;
                if (accept && last_sample)
                begin
                    mx_next    = DP_W'(sumsq_n);
                    my_next    = DP_W'(count_n);
                    acc_next   = '0;
                    iter_next  = ITER_W'(CNT_W - 1);
                    state_next = ST_MUL_NS;
                end
            end
            ST_MUL_NS, ST_MUL_S2, ST_MUL_NN:
            begin
                acc_next = alu_rsp.result;
                mx_next  = {mx_reg[DP_W-2:0], 1'b0};
                my_next  = {1'b0, my_reg[DP_W-1:1]};
                if (iter_done)
                begin
                    unique case (state_reg)
                        ST_MUL_NS:
                        begin
                            num_next   = alu_rsp.result;
                            acc_next   = '0;
                            mx_next    = DP_W'(smag_reg);
                            my_next    = DP_W'(smag_reg);
                            iter_next  = ITER_W'(SUM_W - 1);
                            state_next = ST_MUL_S2;
                        end
                        ST_MUL_S2:
                        begin
                            state_next = ST_DIFF;
                        end
                        default:
                        begin
                            den_next   = alu_rsp.result;
                            acc_next   = '0;
                            mx_next    = '0;
                            my_next    = DP_W'(smag_reg) << FRAC_BITS;
                            iter_next  = ITER_W'(DP_W - 1);
                            state_next = ST_DIV_MEAN;
                        end
                    endcase
                end
            end
            ST_DIFF:
            begin
                num_next   = alu_rsp.borrow ? '0 : alu_rsp.result;
                acc_next   = '0;
                mx_next    = DP_W'(n_reg);
                my_next    = DP_W'(n_reg);
                iter_next  = ITER_W'(CNT_W - 1);
                state_next = ST_MUL_NN;
            end
            ST_DIV_MEAN, ST_DIV_VAR:
            begin
                acc_next = alu_rsp.borrow ? rem_shift : alu_rsp.result;
                my_next  = {my_reg[DP_W-2:0], 1'b0};
                mx_next  = {mx_reg[DP_W-2:0], !alu_rsp.borrow};
                if (iter_done)
                begin
                    if (state_reg == ST_DIV_MEAN)
                    begin
                        mean_next  = neg_reg ? MEAN_W'(-mx_next[MEAN_W-1:0])
                                             : mx_next[MEAN_W-1:0];
                        acc_next   = '0;
                        mx_next    = '0;
                        my_next    = num_reg;
                        iter_next  = ITER_W'(DP_W + 2 * FRAC_BITS - 1);
                        state_next = ST_DIV_VAR;
                    end
                    else
                    begin
                        num_next   = mx_next;
                        mx_next    = '0;
                        my_next    = DP_W'(1) << (DP_W - 2);
                        iter_next  = ITER_W'(SQRT_ITERS - 1);
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT:
            begin
                if (!alu_rsp.borrow)
                begin
                    num_next = alu_rsp.result;
                    mx_next  = {1'b0, mx_reg[DP_W-1:1]} | my_reg;
                end
                else
                begin
                    mx_next = {1'b0, mx_reg[DP_W-1:1]};
                end
                my_next = {2'b00, my_reg[DP_W-1:2]};
                if (iter_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                iter_next  = iter_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            if (state_reg == ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mx_reg   <= mx_next;
        my_reg   <= my_next;
        acc_reg  <= acc_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        mean_reg <= mean_next;
        if (accept && last_sample)
        begin
            smag_reg     <= sum_n[SUM_W-1] ? SUM_W'(-sum_n) : SUM_W'(sum_n);
            neg_reg      <= sum_n[SUM_W-1];
            n_reg        <= count_n;
            min_hold_reg <= min_n;
            max_hold_reg <= max_n;
            ovf_hold_reg <= ovf_n;
        end
        if (state_reg == ST_DONE)
        begin
            minimum      <= min_hold_reg;
            maximum      <= max_hold_reg;
            mean_q8      <= mean_reg;
            stddev_q8    <= mx_reg[SD_W-1:0];
            sample_count <= COUNT_W'(n_reg);
            overflow     <= ovf_hold_reg;
        end
    end

endmodule

// File: design/mmms_checker.sv
// ----------------------------------------------------------------------------
// mmms_checker
// Port-level checks of the statistics block, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_max_mean_stddev_macros.svh"

module mmms_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_ready,
    input logic                                   last_sample,
    input logic                                   out_valid,
    input logic                                   out_ready,
    input logic signed [mmms_pkg::SAMPLE_BITS-1:0] minimum,
    input logic signed [mmms_pkg::SAMPLE_BITS-1:0] maximum,
    input logic [mmms_pkg::COUNT_W-1:0]            sample_count
);
    import mmms_pkg::*;

    `MMMS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_count), "result dropped while stalled")
    `MMMS_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && last_sample, !in_ready, "sample taken during computation")
    `MMMS_ASSERT_NOW(a_no_take_pending, out_valid, !in_ready, "sample taken while result pending")
    `MMMS_ASSERT_NOW(a_min_le_max, out_valid, (minimum <= maximum) && (sample_count != '0), "inconsistent result")

endmodule

bind min_max_mean_stddev mmms_checker u_mmms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .last_sample  (last_sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .minimum      (minimum),
    .maximum      (maximum),
    .sample_count (sample_count)
);

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streaming min/max/mean/stddev block. Sample
// sets are sent over a valid/ready channel while a running predictor keeps
// its own statistics and queues one expected summary per closed set. Every
// summary is compared field by field. Directed, long extreme-value and
// random sets run with random idle bursts on both channels, then quiet sets.
// ----------------------------------------------------------------------------
module tb_top;
    import mmms_pkg::*;

    localparam int     FULL_COUNT = 65536;
    localparam longint SMAX       = 32767;
    localparam longint SMIN       = -32768;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] lo;
        logic signed [SAMPLE_BITS-1:0] hi;
        logic [MEAN_W-1:0]             mean;
        logic [SD_W-1:0]               sd;
        logic [COUNT_W-1:0]            cnt;
        logic                          ovf;
    } summary_t;

    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] sample       = '0;
    logic                          last_sample  = 1'b0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [MEAN_W-1:0]      mean_q8;
    logic [SD_W-1:0]               stddev_q8;
    logic [COUNT_W-1:0]            sample_count;
    logic                          overflow;

    summary_t pending_summaries[$];
    int       mismatches  = 0;
    int       items_sent  = 0;
    bit       idling_on   = 1'b1;
    int       stall_left  = 0;

    longint   acc_min, acc_max, acc_sum;
    logic [63:0] acc_sq;
    longint   acc_n;
    bit       acc_ovf;

    min_max_mean_stddev u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last_sample  (last_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .minimum      (minimum),
        .maximum      (maximum),
        .mean_q8      (mean_q8),
        .stddev_q8    (stddev_q8),
        .sample_count (sample_count),
        .overflow     (overflow)
    );

    always #4 clk = ~clk;

    task automatic clear_stats();
        acc_min = 0;
        acc_max = 0;
        acc_sum = 0;
        acc_sq  = '0;
        acc_n   = 0;
        acc_ovf = 1'b0;
    endtask

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v)
                root = trial;
        end
        return root;
    endfunction

    function automatic summary_t close_set();
        summary_t    s;
        logic [63:0] n, smag, ns, s2, num, mag;
        logic [79:0] var_q;
        n    = acc_n;
        smag = (acc_sum < 0) ? -acc_sum : acc_sum;
        mag  = '0;
        s.sd = '0;
        if (n != 0)
        begin
            ns    = n * acc_sq;
            s2    = smag * smag;
            num   = (ns > s2) ? ns - s2 : 64'd0;
            mag   = (smag << FRAC_BITS) / n;
            var_q = {num, 16'd0} / {16'd0, n * n};
            s.sd  = SD_W'(floor_sqrt(var_q[63:0]));
        end
        s.mean = (acc_sum < 0) ? MEAN_W'(-mag) : MEAN_W'(mag);
        s.lo   = SAMPLE_BITS'(acc_min);
        s.hi   = SAMPLE_BITS'(acc_max);
        s.cnt  = COUNT_W'(n);
        s.ovf  = acc_ovf;
        return s;
    endfunction

    task automatic predict(logic signed [SAMPLE_BITS-1:0] s, logic last);
        longint v;
        v = s;
        if (acc_n < FULL_COUNT)
        begin
            if (acc_n == 0)
            begin
                acc_min = v;
                acc_max = v;
            end
            else
            begin
                if (v < acc_min) acc_min = v;
                if (v > acc_max) acc_max = v;
            end
            acc_sum += v;
            acc_sq  += v * v;
            acc_n++;
        end
        else
            acc_ovf = 1'b1;
        if (last)
        begin
            pending_summaries.push_back(close_set());
            clear_stats();
        end
    endtask

    task automatic send_sample(longint s, bit last);
        int gap;
        if (idling_on && ($urandom_range(0, 4) == 0))
        begin
            gap = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= s[SAMPLE_BITS-1:0];
        last_sample <= last;
        do
            @(posedge clk);
        while (!in_ready);
        predict(s[SAMPLE_BITS-1:0], last);
        items_sent++;
    endtask

    task automatic report(string what, longint got, longint exp);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        summary_t e;
        if (out_valid && out_ready)
        begin
            if (pending_summaries.size() == 0)
                report("unexpected transaction", 0, 0);
            else
            begin
                e = pending_summaries.pop_front();
                if (minimum !== e.lo)       report("minimum", minimum, e.lo);
                if (maximum !== e.hi)       report("maximum", maximum, e.hi);
                if (mean_q8 !== e.mean)     report("mean_q8", mean_q8, $signed(e.mean));
                if (stddev_q8 !== e.sd)     report("stddev_q8", stddev_q8, e.sd);
                if (sample_count !== e.cnt) report("sample_count", sample_count, e.cnt);
                if (overflow !== e.ovf)     report("overflow", overflow, e.ovf);
            end
        end
        if (idling_on && stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idling_on && $urandom_range(0, 5) == 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 7);
        end
        else
            out_ready <= 1'b1;
    end

    function automatic longint pick_value();
        case ($urandom_range(0, 5))
            0: return SMIN;
            1: return SMAX;
            2: return longint'($signed($urandom_range(0, 15))) - 8;
            default: return longint'($signed(16'($urandom())));
        endcase
    endfunction

    task automatic test_directed();
        send_sample(SMAX, 1);
        send_sample(SMIN, 1);
        send_sample(SMIN, 0);
        send_sample(SMAX, 1);
        send_sample(0, 0);
        send_sample(0, 1);
        send_sample(1, 0);
        send_sample(2, 0);
        send_sample(3, 1);
        send_sample(-1, 0);
        send_sample(-2, 1);
        send_sample(-5, 0);
        send_sample(7, 0);
        send_sample(-5, 0);
        send_sample(1, 1);
        send_sample(-21846, 0);
        send_sample(21845, 0);
        send_sample(-1, 1);
    endtask

    task automatic test_long_sets();
        for (int i = 0; i < 128; i++)
            send_sample(SMIN, i == 127);
        for (int i = 0; i < 128; i++)
            send_sample((i % 2) ? SMAX : SMIN, i == 127);
    endtask

    task automatic test_random_sets(int target);
        int len;
        while (items_sent < target)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 200)
                                              : $urandom_range(1, 16);
            for (int i = 0; i < len; i++)
                send_sample(pick_value(), i == len - 1);
        end
    endtask

    task automatic test_quiet_tail();
        idling_on = 1'b0;
        for (int k = 0; k < 8; k++)
            for (int i = 0; i < 5; i++)
                send_sample(pick_value(), i == 4);
    endtask

    initial
    begin
        clear_stats();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_long_sets();
        test_random_sets(1000);
        test_quiet_tail();
        in_valid <= 1'b0;
        while (pending_summaries.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && pending_summaries.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: sim.f
+incdir+design
design/mmms_pkg.sv
design/mmms_alu.sv
design/mmms_accum.sv
design/min_max_mean_stddev.sv
design/mmms_checker.sv
sim/tb_top.sv
